// ----- design/spfb_pkg.sv -----
`default_nettype none
package spfb_pkg;

   localparam int MaxVertsDef = 64;
   localparam int CoordW      = 32;
   localparam int StW         = 24;
   localparam int NumW        = CoordW + 1;
   localparam int FaceW       = 3;
   localparam int CountOutW   = 7;
   localparam int DepthW      = 16;
   localparam int NumFaces    = 6;

   localparam logic signed [StW-1:0] ST_MAX = 24'sh7FFFFF;
   localparam logic signed [StW-1:0] ST_MIN = -24'sh800000;
   localparam logic [DepthW-1:0] MIN_DEPTH_RST = 16'd1;

   // cube faces
   localparam logic [FaceW-1:0] FACE_PX = 3'd0;
   localparam logic [FaceW-1:0] FACE_NX = 3'd1;
   localparam logic [FaceW-1:0] FACE_PY = 3'd2;
   localparam logic [FaceW-1:0] FACE_NY = 3'd3;
   localparam logic [FaceW-1:0] FACE_PZ = 3'd4;
   localparam logic [FaceW-1:0] FACE_NZ = 3'd5;

   // item modes
   localparam logic MODE_CLEAR  = 1'b0;
   localparam logic MODE_VERTEX = 1'b1;

   typedef struct packed {
      logic                     mode;
      logic signed [CoordW-1:0] vertex_x;
      logic signed [CoordW-1:0] vertex_y;
      logic signed [CoordW-1:0] vertex_z;
      logic                     last_vertex;
   } req_type;

   typedef struct packed {
      logic [FaceW-1:0]      face;
      logic signed [StW-1:0] min_s;
      logic signed [StW-1:0] min_t;
      logic signed [StW-1:0] max_s;
      logic signed [StW-1:0] max_t;
      logic [CountOutW-1:0]  projected_count;
      logic                  overflow;
   } rsp_type;

   typedef struct packed {
      logic signed [NumW-1:0] s_num;
      logic signed [NumW-1:0] t_num;
      logic signed [NumW-1:0] depth;
   } proj_type;

   // divider handshake
   typedef struct packed {
      logic                   start;
      logic signed [NumW-1:0] num;
      logic [CoordW-1:0]      den;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic signed [StW-1:0] quo;
   } div_rsp_type;

   // sign and axis permutation per face
   function automatic proj_type face_proj(input logic [FaceW-1:0] face,
                                          input logic signed [CoordW-1:0] x,
                                          input logic signed [CoordW-1:0] y,
                                          input logic signed [CoordW-1:0] z);
      logic signed [NumW-1:0] xe;
      logic signed [NumW-1:0] ye;
      logic signed [NumW-1:0] ze;
      proj_type p;
      xe = {x[CoordW-1], x};
      ye = {y[CoordW-1], y};
      ze = {z[CoordW-1], z};
      unique case (face)
         FACE_PX: begin p.s_num = -ye; p.t_num = ze;  p.depth = xe;  end
         FACE_NX: begin p.s_num = ye;  p.t_num = ze;  p.depth = -xe; end
         FACE_PY: begin p.s_num = xe;  p.t_num = ze;  p.depth = ye;  end
         FACE_NY: begin p.s_num = -xe; p.t_num = ze;  p.depth = -ye; end
         FACE_PZ: begin p.s_num = -ye; p.t_num = -xe; p.depth = ze;  end
         FACE_NZ: begin p.s_num = -ye; p.t_num = xe;  p.depth = -ze; end
         default: begin p.s_num = '0;  p.t_num = '0;  p.depth = '0;  end
      endcase
      return p;
   endfunction

endpackage
`default_nettype wire

// ----- design/sky_polygon_face_bounds.sv -----
`default_nettype none
// Sky polygon face bounds.
// Vertex items (mode 1) come in on req_valid/req_ready with req_data; each is
// stored and summed while room remains (else overflow is set), and the one
// marked last closes the polygon. The block then picks the cube face of the
// dominant summed axis, projects every stored vertex onto it and widens that
// face's s/t box; one result item leaves on rsp_valid/rsp_ready. A clear item
// (mode 0) empties all six boxes at once. Closing a polygon goes through
// S_FACE, then S_READ and S_CHECK per vertex, with S_DIVS and S_DIVT for one
// that passes the depth test, then S_DONE: the shared divider yields one
// quotient bit per cycle and runs twice per passing vertex, and a saturating
// quotient skips the bit-serial steps. req_ready is low while a polygon is
// projected. A result waiting on a stalled receiver does not block vertex or
// clear items; a further closing polygon waits for the output register.
// min_depth is written through csr_wr_en/csr_wr_data.
// Synchronous reset empties the polygon, the boxes and the output register
// and sets min_depth to 1; the vertex memory is not cleared.
module sky_polygon_face_bounds #(
   parameter int MAX_VERTS = spfb_pkg::MaxVertsDef
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire spfb_pkg::req_type               req_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output spfb_pkg::rsp_type                    rsp_data,
   input  wire logic                            csr_wr_en,
   input  wire logic [spfb_pkg::DepthW-1:0]     csr_wr_data
);
   import spfb_pkg::*;

   localparam int AW    = $clog2(MAX_VERTS);
   localparam int CNTW  = $clog2(MAX_VERTS + 1);
   localparam int SUMW  = CoordW + AW + 1;
   localparam int VW    = 3 * CoordW;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_FACE  = 3'd1;
   localparam logic [2:0] S_READ  = 3'd2;
   localparam logic [2:0] S_CHECK = 3'd3;
   localparam logic [2:0] S_DIVS  = 3'd4;
   localparam logic [2:0] S_DIVT  = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   logic [2:0]            state_ff, state_in;
   logic [DepthW-1:0]     min_depth_ff;
   logic [CNTW-1:0]       count_ff, count_in;
   logic [CNTW-1:0]       idx_ff, idx_in;
   logic [CNTW-1:0]       passed_ff, passed_in;
   logic signed [SUMW-1:0] sum_x_ff, sum_x_in;
   logic signed [SUMW-1:0] sum_y_ff, sum_y_in;
   logic signed [SUMW-1:0] sum_z_ff, sum_z_in;
   logic                  ovf_ff, ovf_in;
   logic [FaceW-1:0]      face_ff, face_in;
   logic [VW-1:0]         rd_ff;
   logic signed [NumW-1:0] t_num_ff, t_num_in;
   logic [CoordW-1:0]     den_ff, den_in;
   logic signed [StW-1:0] s_q_ff, s_q_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic signed [StW-1:0] min_s_ff [NumFaces];
   logic signed [StW-1:0] min_t_ff [NumFaces];
   logic signed [StW-1:0] max_s_ff [NumFaces];
   logic signed [StW-1:0] max_t_ff [NumFaces];

   logic [VW-1:0]         mem [MAX_VERTS];

   logic                  accept;
   logic                  is_vertex;
   logic                  has_room;
   logic                  box_clear;
   logic                  box_update;
   logic [SUMW-1:0]       abs_x, abs_y, abs_z;
   proj_type              proj;
   logic                  skip;
   logic                  out_free;
   logic signed [StW-1:0] new_min_s, new_min_t, new_max_s, new_max_t;
   div_req_type           div_req;
   div_rsp_type           div_rsp;

   spfb_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign is_vertex = req_data.mode == MODE_VERTEX;
   assign has_room  = count_ff < CNTW'(MAX_VERTS);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // face choice and projection operands
   always_comb begin
      abs_x = sum_x_ff[SUMW-1] ? SUMW'(-sum_x_ff) : SUMW'(sum_x_ff);
      abs_y = sum_y_ff[SUMW-1] ? SUMW'(-sum_y_ff) : SUMW'(sum_y_ff);
      abs_z = sum_z_ff[SUMW-1] ? SUMW'(-sum_z_ff) : SUMW'(sum_z_ff);
      proj  = face_proj(face_ff, rd_ff[VW-1 -: CoordW], rd_ff[2*CoordW-1 -: CoordW],
                        rd_ff[CoordW-1:0]);
      skip  = proj.depth[NumW-1] || (proj.depth == '0) ||
              (proj.depth < $signed({1'b0, 16'd0, min_depth_ff}));
   end

   // box values after this vertex
   always_comb begin
      new_min_s = (min_s_ff[face_ff] > s_q_ff) ? s_q_ff : min_s_ff[face_ff];
      new_max_s = (max_s_ff[face_ff] < s_q_ff) ? s_q_ff : max_s_ff[face_ff];
      new_min_t = (min_t_ff[face_ff] > div_rsp.quo) ? div_rsp.quo : min_t_ff[face_ff];
      new_max_t = (max_t_ff[face_ff] < div_rsp.quo) ? div_rsp.quo : max_t_ff[face_ff];
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      passed_in    = passed_ff;
      sum_x_in     = sum_x_ff;
      sum_y_in     = sum_y_ff;
      sum_z_in     = sum_z_ff;
      ovf_in       = ovf_ff;
      face_in      = face_ff;
      t_num_in     = t_num_ff;
      den_in       = den_ff;
      s_q_in       = s_q_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      box_clear    = 1'b0;
      box_update   = 1'b0;
      div_req      = '{start: 1'b0, num: proj.s_num, den: proj.depth[CoordW-1:0]};
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (!is_vertex) begin
                  box_clear = 1'b1;
               end else begin
                  if (has_room) begin
                     count_in = count_ff + 1'b1;
                     sum_x_in = sum_x_ff + SUMW'(req_data.vertex_x);
                     sum_y_in = sum_y_ff + SUMW'(req_data.vertex_y);
                     sum_z_in = sum_z_ff + SUMW'(req_data.vertex_z);
                  end else begin
                     ovf_in = 1'b1;
                  end
                  if (req_data.last_vertex) begin
                     state_in = S_FACE;
                  end
               end
            end
         end
         S_FACE: begin
            if (abs_x > abs_y && abs_x > abs_z) begin
               face_in = sum_x_ff[SUMW-1] ? FACE_NX : FACE_PX;
            end else if (abs_y > abs_z && abs_y > abs_x) begin
               face_in = sum_y_ff[SUMW-1] ? FACE_NY : FACE_PY;
            end else begin
               face_in = sum_z_ff[SUMW-1] ? FACE_NZ : FACE_PZ;
            end
            idx_in    = '0;
            passed_in = '0;
            state_in  = S_READ;
         end
         S_READ: begin
            state_in = (idx_ff == count_ff) ? S_DONE : S_CHECK;
         end
         S_CHECK: begin
            if (skip) begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_READ;
            end else begin
               div_req.start = 1'b1;
               t_num_in      = proj.t_num;
               den_in        = proj.depth[CoordW-1:0];
               state_in      = S_DIVS;
            end
         end
         S_DIVS: begin
            if (div_rsp.done) begin
               s_q_in        = div_rsp.quo;
               div_req.start = 1'b1;
               div_req.num   = t_num_ff;
               div_req.den   = den_ff;
               state_in      = S_DIVT;
            end
         end
         S_DIVT: begin
            if (div_rsp.done) begin
               box_update = 1'b1;
               passed_in  = passed_ff + 1'b1;
               idx_in     = idx_ff + 1'b1;
               state_in   = S_READ;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in           = 1'b1;
               rsp_in.face            = face_ff;
               rsp_in.min_s           = min_s_ff[face_ff];
               rsp_in.min_t           = min_t_ff[face_ff];
               rsp_in.max_s           = max_s_ff[face_ff];
               rsp_in.max_t           = max_t_ff[face_ff];
               rsp_in.projected_count = CountOutW'(passed_ff);
               rsp_in.overflow        = ovf_ff;
               count_in               = '0;
               sum_x_in               = '0;
               sum_y_in               = '0;
               sum_z_in               = '0;
               ovf_in                 = 1'b0;
               state_in               = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         min_depth_ff <= MIN_DEPTH_RST;
         count_ff     <= '0;
         sum_x_ff     <= '0;
         sum_y_ff     <= '0;
         sum_z_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sum_x_ff     <= sum_x_in;
         sum_y_ff     <= sum_y_in;
         sum_z_ff     <= sum_z_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            min_depth_ff <= csr_wr_data;
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      passed_ff <= passed_in;
      face_ff   <= face_in;
      t_num_ff  <= t_num_in;
      den_ff    <= den_in;
      s_q_ff    <= s_q_in;
      rsp_ff    <= rsp_in;
   end

   // face boxes
   always_ff @(posedge clock) begin
      if (reset || box_clear) begin
         for (int i = 0; i < NumFaces; i++) begin
            min_s_ff[i] <= ST_MAX;
            min_t_ff[i] <= ST_MAX;
            max_s_ff[i] <= ST_MIN;
            max_t_ff[i] <= ST_MIN;
         end
      end else if (box_update) begin
         min_s_ff[face_ff] <= new_min_s;
         min_t_ff[face_ff] <= new_min_t;
         max_s_ff[face_ff] <= new_max_s;
         max_t_ff[face_ff] <= new_max_t;
      end
   end

   // vertex memory
   always_ff @(posedge clock) begin
      if (accept && is_vertex && has_room) begin
         mem[count_ff[AW-1:0]] <= {req_data.vertex_x, req_data.vertex_y, req_data.vertex_z};
      end
      if (state_ff == S_READ) begin
         rd_ff <= mem[idx_ff[AW-1:0]];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

// ----- design/spfb_div.sv -----
`default_nettype none
module spfb_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire spfb_pkg::div_req_type div_req,
   output spfb_pkg::div_rsp_type      div_rsp
);
   import spfb_pkg::*;

   localparam int QW = StW;
   localparam int CW = $clog2(QW + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              neg_ff, neg_in;
   logic [NumW-1:0]   rem_ff, rem_in;
   logic [QW-1:0]     dsh_ff, dsh_in;
   logic [QW-1:0]     q_ff, q_in;
   logic [CoordW-1:0] den_ff, den_in;
   logic signed [QW-1:0] quo_ff, quo_in;

   logic [NumW-1:0]   mag;
   logic [NumW-1:0]   trial;
   logic              fits;
   logic [QW-1:0]     q_next;

   always_comb begin
      mag    = div_req.num[NumW-1] ? NumW'(-div_req.num) : NumW'(div_req.num);
      trial  = {rem_ff[NumW-2:0], dsh_ff[QW-1]};
      fits   = trial >= NumW'(den_ff);
      q_next = {q_ff[QW-2:0], fits};
   end

   // one quotient bit per cycle, saturation found up front
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      q_in    = q_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (div_req.start) begin
         neg_in = div_req.num[NumW-1];
         den_in = div_req.den;
         if ({7'd0, mag} >= {div_req.den, 8'd0}) begin
            done_in = 1'b1;
            quo_in  = div_req.num[NumW-1] ? ST_MIN : ST_MAX;
         end else begin
            busy_in = 1'b1;
            cnt_in  = CW'(QW);
            rem_in  = mag >> 8;
            dsh_in  = {mag[7:0], 16'd0};
            q_in    = '0;
         end
      end else if (busy_ff) begin
         rem_in = fits ? trial - NumW'(den_ff) : trial;
         dsh_in = {dsh_ff[QW-2:0], 1'b0};
         q_in   = q_next;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (neg_ff) begin
               quo_in = (q_next > QW'(8388608)) ? ST_MIN : -$signed(q_next);
            end else begin
               quo_in = (q_next > QW'(8388607)) ? ST_MAX : $signed(q_next);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quo  = quo_ff;

endmodule
`default_nettype wire

// ----- verif/sky_polygon_face_bounds_tb.sv -----
`default_nettype none
module sky_polygon_face_bounds_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import spfb_pkg::*;

   localparam int MaxVerts   = MaxVertsDef;
   localparam int WatchLimit = 20000;
   localparam int ItemGoal   = 1950;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_ready;
   rsp_type              rsp_data;
   logic                 csr_wr_en;
   logic [DepthW-1:0]    csr_wr_data;

   sky_polygon_face_bounds #(.MAX_VERTS(MaxVerts)) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // clock
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // predicted block state
   longint               poly_x[MaxVerts];
   longint               poly_y[MaxVerts];
   longint               poly_z[MaxVerts];
   int                   poly_count;
   longint               sum_x, sum_y, sum_z;
   bit                   poly_overflow;
   logic signed [StW-1:0] box_min_s[NumFaces];
   logic signed [StW-1:0] box_min_t[NumFaces];
   logic signed [StW-1:0] box_max_s[NumFaces];
   logic signed [StW-1:0] box_max_t[NumFaces];
   logic [DepthW-1:0]    depth_floor;

   rsp_type              expected_bounds[$];
   int                   error_count;
   int                   items_sent;
   int                   idle_cycles;
   bit                   calm;

   function automatic longint abs_l(input longint v);
      return v < 0 ? -v : v;
   endfunction

   // signed axis code per face and role: 0 s, 1 t, 2 depth; +k axis k, -k negated
   function automatic int face_code(input logic [FaceW-1:0] f, input int role);
      int codes[3];
      case (f)
         FACE_PX: codes = '{-2, 3, 1};
         FACE_NX: codes = '{2, 3, -1};
         FACE_PY: codes = '{1, 3, 2};
         FACE_NY: codes = '{-1, 3, -2};
         FACE_PZ: codes = '{-2, -1, 3};
         default: codes = '{-2, 1, -3};
      endcase
      return codes[role];
   endfunction

   function automatic longint axis_pick(input longint x, input longint y, input longint z,
                                        input int code);
      longint v;
      case (code < 0 ? -code : code)
         1: v = x;
         2: v = y;
         default: v = z;
      endcase
      return code < 0 ? -v : v;
   endfunction

   function automatic logic signed [StW-1:0] st_quotient(input longint num, input longint den);
      longint q;
      q = (num * 65536) / den;
      if (q > 64'sd8388607) q = 64'sd8388607;
      if (q < -64'sd8388608) q = -64'sd8388608;
      return q[StW-1:0];
   endfunction

   function automatic void empty_boxes();
      for (int f = 0; f < NumFaces; f++) begin
         box_min_s[f] = ST_MAX;
         box_min_t[f] = ST_MAX;
         box_max_s[f] = ST_MIN;
         box_max_t[f] = ST_MIN;
      end
   endfunction

   // advance the predicted state by one accepted item
   function automatic void predict_bounds(input req_type it);
      longint ax, ay, az, dv;
      logic [FaceW-1:0] f;
      logic signed [StW-1:0] s, t;
      int passed;
      rsp_type r;
      passed = 0;
      if (it.mode == MODE_CLEAR) begin
         empty_boxes();
         return;
      end
      if (poly_count < MaxVerts) begin
         poly_x[poly_count] = it.vertex_x;
         poly_y[poly_count] = it.vertex_y;
         poly_z[poly_count] = it.vertex_z;
         poly_count++;
         sum_x += it.vertex_x;
         sum_y += it.vertex_y;
         sum_z += it.vertex_z;
      end else begin
         poly_overflow = 1'b1;
      end
      if (!it.last_vertex) return;
      ax = abs_l(sum_x);
      ay = abs_l(sum_y);
      az = abs_l(sum_z);
      if (ax > ay && ax > az) f = sum_x < 0 ? FACE_NX : FACE_PX;
      else if (ay > az && ay > ax) f = sum_y < 0 ? FACE_NY : FACE_PY;
      else f = sum_z < 0 ? FACE_NZ : FACE_PZ;
      for (int i = 0; i < poly_count; i++) begin
         dv = axis_pick(poly_x[i], poly_y[i], poly_z[i], face_code(f, 2));
         if (dv <= 0 || dv < longint'(depth_floor)) continue;
         s = st_quotient(axis_pick(poly_x[i], poly_y[i], poly_z[i], face_code(f, 0)), dv);
         t = st_quotient(axis_pick(poly_x[i], poly_y[i], poly_z[i], face_code(f, 1)), dv);
         passed++;
         if (box_min_s[f] > s) box_min_s[f] = s;
         if (box_min_t[f] > t) box_min_t[f] = t;
         if (box_max_s[f] < s) box_max_s[f] = s;
         if (box_max_t[f] < t) box_max_t[f] = t;
      end
      r.face            = f;
      r.min_s           = box_min_s[f];
      r.min_t           = box_min_t[f];
      r.max_s           = box_max_s[f];
      r.max_t           = box_max_t[f];
      r.projected_count = passed[CountOutW-1:0];
      r.overflow        = poly_overflow;
      expected_bounds.push_back(r);
      poly_count    = 0;
      sum_x         = 0;
      sum_y         = 0;
      sum_z         = 0;
      poly_overflow = 1'b0;
   endfunction

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (calm) return 0;
      if (roll < 65) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // send one item and wait for its acceptance
   task automatic send_item(input req_type it);
      int gap;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (!req_ready);
      predict_bounds(it);
      items_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic send_vertex(input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z, input logic last);
      req_type it;
      it.mode        = MODE_VERTEX;
      it.vertex_x    = x;
      it.vertex_y    = y;
      it.vertex_z    = z;
      it.last_vertex = last;
      send_item(it);
   endtask

   task automatic send_clear();
      req_type it;
      it.mode        = MODE_CLEAR;
      it.vertex_x    = $urandom;
      it.vertex_y    = $urandom;
      it.vertex_z    = $urandom;
      it.last_vertex = 1'($urandom_range(0, 1));
      send_item(it);
   endtask

   // wait until the block is idle, then write min_depth
   task automatic set_min_depth(input logic [DepthW-1:0] value);
      @(negedge clock);
      req_valid <= 1'b0;
      wait (expected_bounds.size() == 0);
      repeat (10) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      depth_floor = value;
   endtask

   // random polygon aimed at one face, magnitudes mostly up to 2^(bits+1)
   task automatic send_polygon(input logic [FaceW-1:0] f, input int n, input int bits);
      longint a, b, d;
      longint x, y, z;
      int roll;
      for (int i = 0; i < n; i++) begin
         roll = $urandom_range(0, 99);
         d = longint'($urandom) >> (32 - bits);
         if (roll < 8) d = -d;
         else if (roll < 14) d = longint'(depth_floor) + $urandom_range(0, 2) - 1;
         a = longint'($signed($urandom)) >>> (32 - ((bits + 2) > 31 ? 31 : bits + 2));
         b = longint'($signed($urandom)) >>> (32 - ((bits + 2) > 31 ? 31 : bits + 2));
         case (f)
            FACE_PX: begin x = d;  y = a;  z = b;  end
            FACE_NX: begin x = -d; y = a;  z = b;  end
            FACE_PY: begin x = a;  y = d;  z = b;  end
            FACE_NY: begin x = a;  y = -d; z = b;  end
            FACE_PZ: begin x = a;  y = b;  z = d;  end
            default: begin x = a;  y = b;  z = -d; end
         endcase
         if ($urandom_range(0, 99) < 3) begin
            x = $urandom;
            y = $urandom;
            z = $urandom;
         end
         send_vertex(x[31:0], y[31:0], z[31:0], i == n - 1);
      end
   endtask

   // receiver: random stalls, few long ones, none while calm
   int stall_left;
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else if (calm) begin
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ready  <= 1'b1;
         if ($urandom_range(0, 99) < 20)
            stall_left <= ($urandom_range(0, 99) < 90) ? $urandom_range(1, 3)
                                                       : $urandom_range(10, 60);
      end
   end

   function automatic void check_field(input string name, input longint exp_v,
                                       input longint act_v);
      if (exp_v != act_v) begin
         $display("%0t mismatch %s: expected %0d actual %0d", $time, name, exp_v, act_v);
         error_count++;
      end
   endfunction

   // compare each result item with the oldest prediction
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_bounds.size() == 0) begin
            $display("%0t unexpected result item face %0d", $time, rsp_data.face);
            error_count++;
         end else begin
            e = expected_bounds.pop_front();
            check_field("face", e.face, rsp_data.face);
            check_field("min_s", e.min_s, rsp_data.min_s);
            check_field("min_t", e.min_t, rsp_data.min_t);
            check_field("max_s", e.max_s, rsp_data.max_s);
            check_field("max_t", e.max_t, rsp_data.max_t);
            check_field("projected_count", e.projected_count, rsp_data.projected_count);
            check_field("overflow", e.overflow, rsp_data.overflow);
         end
      end
   end

   // watchdog on cycles without any accepted item, result or min_depth write
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wr_en)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // empty boxes, zero sum and zero depth right after reset
   task automatic test_reset_state();
      send_vertex(32'd0, 32'd0, 32'd0, 1'b0);
      send_vertex(32'd0, 32'd0, 32'd0, 1'b1);
      send_vertex(32'd5, 32'd5, 32'd0, 1'b1);
   endtask

   // field extremes and saturated quotients
   task automatic test_extremes();
      send_vertex(32'h0000_0100, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
      send_vertex(32'h7FFF_FFFF, 32'h0, 32'h0, 1'b1);
      send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
      send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h1, 1'b0);
      send_vertex(32'h1, 32'h1, 32'h7FFF_FFFF, 1'b1);
      send_vertex(32'h8000_0000, 32'h1, 32'hFFFF_FFFF, 1'b1);
   endtask

   // one polygon per face plus axis ties
   task automatic test_faces_and_ties();
      for (int f = 0; f < NumFaces; f++)
         send_polygon(f[FaceW-1:0], 2, 16);
      send_vertex(32'd100, 32'd100, 32'd50, 1'b1);
      send_vertex(32'd10, 32'hFFFF_FF9C, 32'd100, 1'b1);
   endtask

   // depth threshold edges, min_depth of zero and of 16'hFFFF
   task automatic test_depth_threshold();
      set_min_depth(16'd0);
      send_vertex(32'd3, 32'd4, 32'd0, 1'b0);
      send_vertex(32'd3, 32'd4, 32'd1, 1'b1);
      set_min_depth(16'hFFFF);
      send_vertex(32'd7, 32'd9, 32'h0000_FFFE, 1'b0);
      send_vertex(32'd7, 32'd9, 32'h0000_FFFF, 1'b1);
   endtask

   // clear arriving in the middle of a polygon
   task automatic test_clear_mid_polygon();
      send_vertex(32'd256, 32'd10, 32'd20, 1'b0);
      send_clear();
      send_vertex(32'd512, 32'hFFFF_FF00, 32'd40, 1'b1);
   endtask

   // random phases across several min_depth settings
   task automatic test_random_polygons();
      logic [DepthW-1:0] floors[5];
      int phase, roll, n, goal;
      floors = '{16'd1, 16'd0, 16'hFFFF, 16'd256, 16'd0};
      phase = 0;
      goal  = items_sent + ItemGoal;
      while (items_sent < goal) begin
         if (items_sent >= goal - ItemGoal + (phase + 1) * 380) begin
            phase++;
            set_min_depth(phase < 5 ? floors[phase] : 16'($urandom));
            calm = (phase == 2);
         end
         roll = $urandom_range(0, 99);
         if (roll < 5) begin
            send_clear();
         end else if (roll < 8) begin
            // noise vertex with a random last flag
            send_vertex($urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
         end else begin
            n = ($urandom_range(0, 99) < 2) ? $urandom_range(60, 70) : $urandom_range(1, 8);
            send_polygon(FaceW'($urandom_range(0, NumFaces - 1)), n,
                         ($urandom_range(0, 3) == 0) ? 30 : $urandom_range(4, 24));
         end
      end
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      csr_wr_en     = 1'b0;
      csr_wr_data   = '0;
      error_count   = 0;
      items_sent    = 0;
      calm          = 1'b0;
      poly_count    = 0;
      sum_x         = 0;
      sum_y         = 0;
      sum_z         = 0;
      poly_overflow = 1'b0;
      depth_floor   = MIN_DEPTH_RST;
      empty_boxes();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_extremes();
      test_faces_and_ties();
      test_depth_threshold();
      test_clear_mid_polygon();
      set_min_depth(MIN_DEPTH_RST);
      test_random_polygons();

      // drain
      @(negedge clock);
      req_valid <= 1'b0;
      wait (expected_bounds.size() == 0);
      repeat (100) @(posedge clock);
      if (error_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
`default_nettype wire
